FILE: hw/rtl/brc_pkg.sv
// ----------------------------------------------------------------------------
// brc_pkg - shared types and constants of the operation result cache
// Holds item kind codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int KIND_BITS        = 2;
  localparam int PORT_HANDLE_BITS = 32;
  localparam int IDX_BITS         = 16;
  localparam int OP_BITS          = 8;
  localparam int LEN_BITS         = 11;
  localparam int SLOT_BITS        = 10;
  localparam int SUM_BITS         = 40;
  localparam int DIV_CNT_BITS     = 6;
  localparam int HIGH_SHIFT       = 4;
  localparam int LOW_SHIFT        = 5;

  localparam logic [LEN_BITS-1:0] TABLE_LENGTH_RESET = 11'd1024;

  localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TOTAL,
    ST_DIV,
    ST_ACCESS,
    ST_CLEAR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_LOOKUP,
    RES_INSERT
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     div_step;
    logic     mem_read;
    logic     mem_write;
    logic     sweep;
    logic     load_out;
    res_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic sweep_last;
  } status_t;

endpackage

FILE: hw/rtl/brc_mod_unit.sv
// ----------------------------------------------------------------------------
// brc_mod_unit - serial remainder unit
// Restoring division of the hash by the slot count, one dividend bit per
// cycle while step is high; only the remainder is kept.
// ----------------------------------------------------------------------------
module brc_mod_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            step,
  input  logic [brc_pkg::SUM_BITS-1:0]    dividend_in,
  input  logic [brc_pkg::LEN_BITS-1:0]    divisor,
  output logic [brc_pkg::LEN_BITS-1:0]    remainder,
  output logic                            last
);

  localparam logic [brc_pkg::DIV_CNT_BITS-1:0] LAST_CNT =
    brc_pkg::DIV_CNT_BITS'(brc_pkg::SUM_BITS - 1);

  logic [brc_pkg::SUM_BITS-1:0]     dividend;
  logic [brc_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [brc_pkg::LEN_BITS:0]       rem_shift;
  logic [brc_pkg::LEN_BITS:0]       rem_next;

  always_comb begin
    rem_shift = {remainder, dividend[brc_pkg::SUM_BITS-1]};
    if (rem_shift >= {1'b0, divisor}) begin
      rem_next = rem_shift - {1'b0, divisor};
    end else begin
      rem_next = rem_shift;
    end
  end

  assign last = (cnt == LAST_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend  <= dividend_in;
      remainder <= '0;
    end else if (step) begin
      dividend  <= {dividend[brc_pkg::SUM_BITS-2:0], 1'b0};
      remainder <= rem_next[brc_pkg::LEN_BITS-1:0];
    end
  end

endmodule

FILE: hw/rtl/brc_datapath.sv
// ----------------------------------------------------------------------------
// brc_datapath - key registers, hash, remainder unit and entry memory
// Carries out the controller's commands and drives the result registers.
// ----------------------------------------------------------------------------
module brc_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int HANDLE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  brc_pkg::cmd_t                           cmd,
  output brc_pkg::status_t                        status,
  input  logic                                    cfg_we,
  input  logic [brc_pkg::LEN_BITS-1:0]            cfg_wdata,
  input  logic [brc_pkg::PORT_HANDLE_BITS-1:0]    high_ref,
  input  logic [brc_pkg::PORT_HANDLE_BITS-1:0]    low_ref,
  input  logic [brc_pkg::IDX_BITS-1:0]            high_index,
  input  logic [brc_pkg::IDX_BITS-1:0]            low_index,
  input  logic [brc_pkg::OP_BITS-1:0]             op_code,
  input  logic [brc_pkg::PORT_HANDLE_BITS-1:0]    new_result,
  output logic                                    hit,
  output logic [brc_pkg::PORT_HANDLE_BITS-1:0]    found_result,
  output logic [brc_pkg::SLOT_BITS-1:0]           slot
);

  localparam int HB = (HANDLE_BITS < brc_pkg::PORT_HANDLE_BITS) ?
                      HANDLE_BITS : brc_pkg::PORT_HANDLE_BITS;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int RW = (IW > brc_pkg::LEN_BITS) ? IW : brc_pkg::LEN_BITS;
  localparam int EW = 1 + brc_pkg::OP_BITS + 3 * HB;
  localparam logic [IW-1:0] SWEEP_LAST = IW'(TABLE_DEPTH - 1);

  logic [brc_pkg::LEN_BITS-1:0] table_length;
  logic [brc_pkg::LEN_BITS-1:0] used_length;
  logic [brc_pkg::LEN_BITS-1:0] divisor;

  logic [HB-1:0]                k_high;
  logic [HB-1:0]                k_low;
  logic [HB-1:0]                k_result;
  logic [brc_pkg::OP_BITS-1:0]  k_op;
  logic [brc_pkg::SUM_BITS-1:0] part_a;
  logic [brc_pkg::SUM_BITS-1:0] part_b;

  logic [brc_pkg::LEN_BITS-1:0] remainder;
  logic                         div_last;
  logic [RW-1:0]                rem_wide;
  logic [IW-1:0]                slot_idx;
  logic [IW-1:0]                sweep_addr;

  logic [EW-1:0]                mem [TABLE_DEPTH];
  logic [EW-1:0]                wr_entry;
  logic [EW-1:0]                rd_entry;

  logic                         rd_valid;
  logic [brc_pkg::OP_BITS-1:0]  rd_op;
  logic [HB-1:0]                rd_high;
  logic [HB-1:0]                rd_low;
  logic [HB-1:0]                rd_result;
  logic                         match;

  // Slot count: zero acts as one, anything past the table depth saturates.
  always_comb begin
    if (table_length == '0) begin
      used_length = brc_pkg::LEN_BITS'(1);
    end else if (32'(table_length) > 32'(TABLE_DEPTH)) begin
      used_length = brc_pkg::LEN_BITS'(TABLE_DEPTH);
    end else begin
      used_length = table_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= brc_pkg::TABLE_LENGTH_RESET;
    end else if (cfg_we) begin
      table_length <= cfg_wdata;
    end
  end

  // Capture the key and form the two halves of the hash sum.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k_high   <= high_ref[HB-1:0];
      k_low    <= low_ref[HB-1:0];
      k_result <= new_result[HB-1:0];
      k_op     <= op_code;
      divisor  <= used_length;
      part_a   <= brc_pkg::SUM_BITS'(high_index) + brc_pkg::SUM_BITS'(low_index)
                + brc_pkg::SUM_BITS'(high_ref[HB-1:0] >> brc_pkg::HIGH_SHIFT);
      part_b   <= brc_pkg::SUM_BITS'(low_ref[HB-1:0] >> brc_pkg::LOW_SHIFT)
                + brc_pkg::SUM_BITS'(high_ref[HB-1:0])
                + brc_pkg::SUM_BITS'(low_ref[HB-1:0]);
    end
  end

  brc_mod_unit u_mod (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.div_start),
    .step        (cmd.div_step),
    .dividend_in (part_a + part_b),
    .divisor     (divisor),
    .remainder   (remainder),
    .last        (div_last)
  );

  assign rem_wide = RW'(remainder);
  assign slot_idx = rem_wide[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep) begin
      sweep_addr <= (sweep_addr == SWEEP_LAST) ? '0 : sweep_addr + 1'b1;
    end
  end

  assign status.div_last   = div_last;
  assign status.sweep_last = (sweep_addr == SWEEP_LAST);

  assign wr_entry = {1'b1, k_op, k_high, k_low, k_result};

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_addr] <= '0;
    end else if (cmd.mem_write) begin
      mem[slot_idx] <= wr_entry;
    end
    if (cmd.mem_read) begin
      rd_entry <= mem[slot_idx];
    end
  end

  assign {rd_valid, rd_op, rd_high, rd_low, rd_result} = rd_entry;
  assign match = rd_valid && (rd_op == k_op) && (rd_high == k_high) && (rd_low == k_low);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.out_sel)
        brc_pkg::RES_LOOKUP: begin
          hit          <= match;
          found_result <= match ? brc_pkg::PORT_HANDLE_BITS'(rd_result) : '0;
          slot         <= remainder[brc_pkg::SLOT_BITS-1:0];
        end
        brc_pkg::RES_INSERT: begin
          hit          <= 1'b0;
          found_result <= '0;
          slot         <= remainder[brc_pkg::SLOT_BITS-1:0];
        end
        default: begin
          hit          <= 1'b0;
          found_result <= '0;
          slot         <= '0;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/brc_ctrl.sv
// ----------------------------------------------------------------------------
// brc_ctrl - sequencing state machine of the operation result cache
// Steps each item through hashing, the serial remainder, the memory access
// and the result register; runs the clearing sweep.
// ----------------------------------------------------------------------------
module brc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [brc_pkg::KIND_BITS-1:0]  kind,
  output logic                           out_valid,
  input  logic                           out_ready,
  output brc_pkg::cmd_t                  cmd,
  input  brc_pkg::status_t               status
);

  brc_pkg::state_t   state;
  brc_pkg::state_t   state_next;
  brc_pkg::res_sel_t res_sel;
  brc_pkg::res_sel_t res_sel_next;
  logic              out_valid_next;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      brc_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = brc_pkg::ST_IDLE;
      end
      brc_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind)
            brc_pkg::KIND_LOOKUP, brc_pkg::KIND_INSERT: state_next = brc_pkg::ST_TOTAL;
            brc_pkg::KIND_CLEAR:                        state_next = brc_pkg::ST_CLEAR;
            default:                                    state_next = brc_pkg::ST_DONE;
          endcase
        end
      end
      brc_pkg::ST_TOTAL:  state_next = brc_pkg::ST_DIV;
      brc_pkg::ST_DIV: begin
        if (status.div_last) state_next = brc_pkg::ST_ACCESS;
      end
      brc_pkg::ST_ACCESS: state_next = brc_pkg::ST_DONE;
      brc_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_next = brc_pkg::ST_DONE;
      end
      brc_pkg::ST_DONE: begin
        if (out_free) state_next = brc_pkg::ST_IDLE;
      end
      default:            state_next = brc_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready      = (state == brc_pkg::ST_IDLE);
    cmd           = '0;
    cmd.out_sel   = res_sel;
    cmd.capture   = accept;
    res_sel_next  = res_sel;
    if (accept) begin
      case (kind)
        brc_pkg::KIND_LOOKUP: res_sel_next = brc_pkg::RES_LOOKUP;
        brc_pkg::KIND_INSERT: res_sel_next = brc_pkg::RES_INSERT;
        default:              res_sel_next = brc_pkg::RES_NONE;
      endcase
    end
    case (state)
      brc_pkg::ST_INIT:   cmd.sweep     = 1'b1;
      brc_pkg::ST_CLEAR:  cmd.sweep     = 1'b1;
      brc_pkg::ST_TOTAL:  cmd.div_start = 1'b1;
      brc_pkg::ST_DIV:    cmd.div_step  = 1'b1;
      brc_pkg::ST_ACCESS: begin
        cmd.mem_write = (res_sel == brc_pkg::RES_INSERT);
        cmd.mem_read  = (res_sel != brc_pkg::RES_INSERT);
      end
      brc_pkg::ST_DONE:   cmd.load_out  = out_free;
      default:            cmd.sweep     = 1'b0;
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brc_pkg::ST_INIT;
      res_sel   <= brc_pkg::RES_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_sel   <= res_sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hw/rtl/bdd_operation_result_cache.sv
// ----------------------------------------------------------------------------
// bdd_operation_result_cache - direct-mapped operation result cache
// Lookup, insert and whole-table clear for decision-diagram operation
// results, keyed on two child handles and an operation tag.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   in        in_valid / in_ready    kind, high_ref, low_ref, high_index,
//                                    low_index, op_code, new_result
//   out       out_valid / out_ready  hit, found_result, slot
//   cfg       cfg_we (no wait)       cfg_wdata = table_length
//
// A lookup or insert runs from acceptance to the output register in steps:
// loading the remainder unit with the hash, the bit-serial remainder of the
// 40-bit hash, the memory port, and loading the result once the output is free.
// An item of unknown kind goes straight to the result; a clear sweeps the entry
// memory one slot a cycle. After reset the same sweep runs with in_ready low.
// One item is in flight at a time; the next is taken while a result waits, and a
// stalled output holds it until out_ready.
//
module bdd_operation_result_cache #(
  parameter int TABLE_DEPTH = 1024,
  parameter int HANDLE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    cfg_we,
  input  logic [brc_pkg::LEN_BITS-1:0]            cfg_wdata,
  // request items
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [brc_pkg::KIND_BITS-1:0]           kind,
  input  logic [brc_pkg::PORT_HANDLE_BITS-1:0]    high_ref,
  input  logic [brc_pkg::PORT_HANDLE_BITS-1:0]    low_ref,
  input  logic [brc_pkg::IDX_BITS-1:0]            high_index,
  input  logic [brc_pkg::IDX_BITS-1:0]            low_index,
  input  logic [brc_pkg::OP_BITS-1:0]             op_code,
  input  logic [brc_pkg::PORT_HANDLE_BITS-1:0]    new_result,
  // result items
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    hit,
  output logic [brc_pkg::PORT_HANDLE_BITS-1:0]    found_result,
  output logic [brc_pkg::SLOT_BITS-1:0]           slot
);

  brc_pkg::cmd_t    cmd;
  brc_pkg::status_t status;

  // Sequence each item; hold the result valid until taken.
  brc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Hash, reduce modulo the slot count, probe or write the entry memory.
  brc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .high_ref     (high_ref),
    .low_ref      (low_ref),
    .high_index   (high_index),
    .low_index    (low_index),
    .op_code      (op_code),
    .new_result   (new_result),
    .hit          (hit),
    .found_result (found_result),
    .slot         (slot)
  );

endmodule

FILE: bench/bdd_operation_result_cache_tb.sv
// ----------------------------------------------------------------------------
// bdd_operation_result_cache_tb - self-checking bench of the result cache
// Drives lookups, inserts, clears and spare-kind items through the request
// channel, predicts each result from a shadow copy of the table where none
// is typed in, and compares each result item field by field. A short directed table comes
// first, then phases of random traffic under several table lengths and
// idling patterns on both channels.
// ----------------------------------------------------------------------------
module bdd_operation_result_cache_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  localparam int STUCK_LIMIT = 10000;
  localparam int PHASE_ITEMS = 250;
  localparam int POOL_DEPTH  = 48;
  // kind three is not decoded by the block: it must answer with all zeros
  localparam logic [brc_pkg::KIND_BITS-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [brc_pkg::KIND_BITS-1:0]        kind;
    logic [brc_pkg::PORT_HANDLE_BITS-1:0] high_ref;
    logic [brc_pkg::PORT_HANDLE_BITS-1:0] low_ref;
    logic [brc_pkg::IDX_BITS-1:0]         high_index;
    logic [brc_pkg::IDX_BITS-1:0]         low_index;
    logic [brc_pkg::OP_BITS-1:0]          op_code;
    logic [brc_pkg::PORT_HANDLE_BITS-1:0] new_result;
  } cache_req_t;

  typedef struct packed {
    logic                                 hit;
    logic [brc_pkg::PORT_HANDLE_BITS-1:0] found_result;
    logic [brc_pkg::SLOT_BITS-1:0]        slot;
  } cache_answer_t;

  // One row of the directed table: either a table length write or an item,
  // with the answer typed in where it is obvious.
  typedef struct packed {
    logic                         set_len;
    logic [brc_pkg::LEN_BITS-1:0] len;
    cache_req_t                   req;
    logic                         typed;
    cache_answer_t                ans;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                                 cfg_we     = 1'b0;
  logic [brc_pkg::LEN_BITS-1:0]         cfg_wdata  = '0;
  logic                                 in_valid   = 1'b0;
  logic                                 in_ready;
  logic [brc_pkg::KIND_BITS-1:0]        kind       = brc_pkg::KIND_LOOKUP;
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] high_ref   = '0;
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] low_ref    = '0;
  logic [brc_pkg::IDX_BITS-1:0]         high_index = '0;
  logic [brc_pkg::IDX_BITS-1:0]         low_index  = '0;
  logic [brc_pkg::OP_BITS-1:0]          op_code    = '0;
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] new_result = '0;
  logic                                 out_valid;
  logic                                 out_ready  = 1'b0;
  logic                                 hit;
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] found_result;
  logic [brc_pkg::SLOT_BITS-1:0]        slot;

  // shadow of the table and its length register
  logic [brc_pkg::LEN_BITS-1:0]         table_len = brc_pkg::TABLE_LENGTH_RESET;
  logic                                 tag_valid     [TABLE_DEPTH];
  logic [brc_pkg::OP_BITS-1:0]          tag_op        [TABLE_DEPTH];
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] tag_high      [TABLE_DEPTH];
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] tag_low       [TABLE_DEPTH];
  logic [brc_pkg::PORT_HANDLE_BITS-1:0] stored_result [TABLE_DEPTH];
  // slots written at least once; lookups are kept to these
  bit                                   slot_written  [TABLE_DEPTH];

  cache_answer_t cache_answer_q[$];
  cache_req_t    key_pool[$];
  dir_row_t      dir_rows[$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned answers_seen   = 0;
  int unsigned stuck_cycles   = 0;

  bdd_operation_result_cache u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .high_ref     (high_ref),
    .low_ref      (low_ref),
    .high_index   (high_index),
    .low_index    (low_index),
    .op_code      (op_code),
    .new_result   (new_result),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .found_result (found_result),
    .slot         (slot)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Zero and oversize lengths fold into the usable range.
  function automatic logic [brc_pkg::LEN_BITS-1:0] active_length();
    if (table_len == '0) return brc_pkg::LEN_BITS'(1);
    if (table_len > TABLE_DEPTH) return brc_pkg::LEN_BITS'(TABLE_DEPTH);
    return table_len;
  endfunction

  // Sum the indices, the shifted handles and the handles in 40 bits, then
  // reduce by the active length.
  function automatic logic [brc_pkg::SLOT_BITS-1:0] hash_slot(input cache_req_t r);
    logic [brc_pkg::SUM_BITS-1:0] sum;
    logic [brc_pkg::SUM_BITS-1:0] rem;
    sum = r.high_index + r.low_index + (r.high_ref >> brc_pkg::HIGH_SHIFT)
        + (r.low_ref >> brc_pkg::LOW_SHIFT) + r.high_ref + r.low_ref;
    rem = sum % active_length();
    return rem[brc_pkg::SLOT_BITS-1:0];
  endfunction

  // Advance the shadow table by one accepted item and return its answer.
  function automatic cache_answer_t compute_cache_answer(input cache_req_t r);
    cache_answer_t a;
    logic [brc_pkg::SLOT_BITS-1:0] s;
    a = '0;
    s = hash_slot(r);
    case (r.kind)
      brc_pkg::KIND_LOOKUP: begin
        // the variable indices steer the slot but are not part of the key
        if (tag_valid[s] && tag_op[s] == r.op_code && tag_high[s] == r.high_ref
            && tag_low[s] == r.low_ref) begin
          a.hit = 1'b1;
          a.found_result = stored_result[s];
        end
        a.slot = s;
      end
      brc_pkg::KIND_INSERT: begin
        tag_valid[s]     = 1'b1;
        tag_op[s]        = r.op_code;
        tag_high[s]      = r.high_ref;
        tag_low[s]       = r.low_ref;
        stored_result[s] = r.new_result;
        slot_written[s]  = 1'b1;
        a.slot = s;
      end
      brc_pkg::KIND_CLEAR: begin
        // drop every valid bit, including slots beyond the active length
        for (int i = 0; i < TABLE_DEPTH; i++) tag_valid[i] = 1'b0;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic void add_row(input logic set_len,
                                  input logic [brc_pkg::LEN_BITS-1:0] len,
                                  input logic [brc_pkg::KIND_BITS-1:0] k,
                                  input logic [31:0] hi, input logic [31:0] lo,
                                  input logic [15:0] hidx, input logic [15:0] lidx,
                                  input logic [7:0] op, input logic [31:0] res,
                                  input logic typed, input logic ehit,
                                  input logic [31:0] efound, input logic [9:0] eslot);
    dir_row_t row;
    row.set_len = set_len;
    row.len     = len;
    row.req     = '{k, hi, lo, hidx, lidx, op, res};
    row.typed   = typed;
    row.ans     = '{ehit, efound, eslot};
    dir_rows.push_back(row);
  endfunction

  function automatic cache_req_t pool_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // Draw one random item. Most traffic is inserts and lookups of recently
  // inserted keys, so that hits, near misses and overwrites all occur.
  function automatic cache_req_t draw_request();
    cache_req_t r;
    int unsigned pick;
    int unsigned tries;
    pick         = $urandom_range(999);
    r.kind       = brc_pkg::KIND_LOOKUP;
    r.high_ref   = $urandom;
    r.low_ref    = $urandom;
    r.high_index = brc_pkg::IDX_BITS'($urandom);
    r.low_index  = brc_pkg::IDX_BITS'($urandom);
    r.op_code    = brc_pkg::OP_BITS'($urandom);
    r.new_result = $urandom;
    if (pick < 10) begin
      r.kind = brc_pkg::KIND_CLEAR;
    end else if (pick < 30) begin
      r.kind = KIND_SPARE;
    end else if (pick < 380 || key_pool.size() == 0) begin
      if ($urandom_range(3) == 0 && key_pool.size() != 0) begin
        // overwrite a recent key with a fresh result
        r = pool_key();
        r.new_result = $urandom;
      end else if ($urandom_range(3) == 0) begin
        // narrow handles crowd the low slots
        r.high_ref   = $urandom_range(63);
        r.low_ref    = $urandom_range(63);
        r.high_index = brc_pkg::IDX_BITS'($urandom_range(7));
        r.low_index  = brc_pkg::IDX_BITS'($urandom_range(7));
      end
      r.kind = brc_pkg::KIND_INSERT;
      key_pool.push_back(r);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end else begin
      r = pool_key();
      r.kind = brc_pkg::KIND_LOOKUP;
      r.new_result = $urandom;
      case ($urandom_range(9))
        0, 1: r.op_code  = r.op_code ^ (8'd1 << $urandom_range(7));
        2:    r.high_ref = r.high_ref ^ (32'd1 << $urandom_range(31));
        3:    r.low_ref  = r.low_ref ^ (32'd1 << $urandom_range(31));
        // same slot through a different index: still a hit
        4:    r.high_index = r.high_index + active_length();
        5: begin
          r.high_ref = $urandom;
          r.low_ref  = $urandom;
        end
        default: begin
        end
      endcase
      // never probe a slot that has not been written since power-up
      tries = 0;
      while (!slot_written[hash_slot(r)] && tries < 8) begin
        r = pool_key();
        r.kind = brc_pkg::KIND_LOOKUP;
        tries++;
      end
      if (!slot_written[hash_slot(r)]) r.kind = brc_pkg::KIND_INSERT;
    end
    return r;
  endfunction

  // Present one item, hold it until accepted, then log its answer. Valid is
  // left high so a back-to-back item needs no second assignment.
  task automatic send_item(input cache_req_t r, input logic typed,
                           input cache_answer_t typed_ans);
    cache_answer_t a;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= r.kind;
    high_ref   <= r.high_ref;
    low_ref    <= r.low_ref;
    high_index <= r.high_index;
    low_index  <= r.low_index;
    op_code    <= r.op_code;
    new_result <= r.new_result;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    a = compute_cache_answer(r);
    cache_answer_q.push_back(typed ? typed_ans : a);
  endtask

  // Write the table length once the block has drained and can take an item.
  task automatic write_table_length(input logic [brc_pkg::LEN_BITS-1:0] len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (cache_answer_q.size() != 0 || !in_ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    table_len = len;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %h want %h", answers_seen, what, got, want);
  endtask

  // Receiver: stall at the phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result item against the oldest awaited answer.
  always @(posedge clk) begin
    cache_answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (cache_answer_q.size() == 0) begin
        report_mismatch("result with no item awaiting it", found_result, '0);
      end else begin
        want = cache_answer_q.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (found_result !== want.found_result)
          report_mismatch("found_result", found_result, want.found_result);
        if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
      end
      answers_seen++;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [brc_pkg::LEN_BITS-1:0] phase_len [8];
    cache_req_t r;
    int unsigned taken;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tag_valid[i]     = 1'b0;
      tag_op[i]        = '0;
      tag_high[i]      = '0;
      tag_low[i]       = '0;
      stored_result[i] = '0;
      slot_written[i]  = 1'b0;
    end

    // Directed table. Keys of all zeros hash to slot 0 at any length.
    add_row(0, 0, brc_pkg::KIND_INSERT, 0, 0, 0, 0, 8'h00, 32'hdeadbeef, 1, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 8'h00, 0, 1, 1, 32'hdeadbeef, 0);
    // wrong operation tag: miss on the same slot
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 8'h01, 0, 1, 0, 0, 0);
    // spare kind with every field at its top: nothing changes, zero answer
    add_row(0, 0, KIND_SPARE, '1, '1, '1, '1, '1, '1, 1, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_CLEAR, '1, '1, '1, '1, '1, '1, 1, 0, 0, 0);
    // the key inserted before the clear no longer hits
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 8'h00, 0, 1, 0, 0, 0);
    // index outside the key: same slot, same key, overwrite
    add_row(0, 0, brc_pkg::KIND_INSERT, 0, 0, 16'd1024, 0, 8'h00, 32'h12345678,
            1, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 8'h00, 0, 0, 0, 0, 0);
    // all fields at their top
    add_row(0, 0, brc_pkg::KIND_INSERT, '1, '1, '1, '1, '1, '1, 0, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, '1, '1, '1, '1, '1, 0, 0, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, '1, '1, '1, '1, 8'hfe, 0, 0, 0, 0, 0);
    // lone top bits
    add_row(0, 0, brc_pkg::KIND_INSERT, 32'h80000000, 32'h1, 16'h8000, 16'h1, 8'h80,
            32'h80000001, 0, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 32'h80000000, 32'h1, 16'h8000, 16'h1, 8'h80,
            0, 0, 0, 0, 0);
    // length zero acts as one: every key lands in slot 0
    add_row(1, 11'd0, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_INSERT, 32'h13, 32'h57, 16'h9, 16'h2, 8'h05,
            32'ha5a5a5a5, 1, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 32'h13, 32'h57, 16'h9, 16'h2, 8'h05, 0,
            1, 1, 32'ha5a5a5a5, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 32'h14, 32'h57, 16'h9, 16'h2, 8'h05, 0,
            1, 0, 0, 0);
    // oversize length saturates to the full table
    add_row(1, 11'd2047, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_INSERT, 0, 0, 16'd1023, 0, 8'h33, 32'h5a5a5a5a,
            1, 0, 0, 10'd1023);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 0, 0, 16'd1023, 0, 8'h33, 0,
            1, 1, 32'h5a5a5a5a, 10'd1023);
    add_row(1, 11'd1, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, brc_pkg::KIND_LOOKUP, 32'h13, 32'h57, 16'h9, 16'h2, 8'h05, 0,
            1, 1, 32'ha5a5a5a5, 0);
    add_row(1, 11'd1024, brc_pkg::KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    phase_len[0] = 11'd1024;
    phase_len[1] = 11'd1;
    phase_len[2] = 11'd0;
    phase_len[3] = 11'd2047;
    phase_len[4] = 11'd1023;
    phase_len[5] = 11'd3;
    phase_len[6] = brc_pkg::LEN_BITS'($urandom_range(2, 1024));
    phase_len[7] = 11'd1024;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table with no idling on either side.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_len) write_table_length(dir_rows[i].len);
      else send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].ans);
    end

    // Random phases: each pattern of idling runs twice, at different lengths.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
        default: begin send_gap_pct = 20; recv_stall_pct = 20; end
      endcase
      write_table_length(phase_len[p]);
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        r = draw_request();
        send_item(r, 1'b0, '0);
        if (r.kind != KIND_SPARE) taken++;
      end
    end

    // Drain, then hold a little past the longest lookup or insert to catch strays.
    in_valid <= 1'b0;
    while (cache_answer_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
